// ----- design/atpcv_pkg.sv -----
// ----------------------------------------------------------------------------
// atpcv_pkg: shared types and constants of the pc-relative value unit
// request kinds, instruction set codes, encoding masks and stage words
// ----------------------------------------------------------------------------
package atpcv_pkg;

    typedef enum logic [4:0] {
        REQ_HANDLER  = 5'd0,
        REQ_ORIG_PC  = 5'd1,
        REQ_READ_PC  = 5'd2,
        REQ_NEXT_PC  = 5'd3,
        REQ_INSN     = 5'd4,
        REQ_CBZ      = 5'd5,
        REQ_ADR_T1   = 5'd6,
        REQ_ADR_T23  = 5'd7,
        REQ_LDR_T1   = 5'd8,
        REQ_LDR_T2   = 5'd9,
        REQ_B_T1     = 5'd10,
        REQ_B_T2     = 5'd11,
        REQ_B_T3     = 5'd12,
        REQ_B_T4     = 5'd13,
        REQ_BLX_T2   = 5'd14,
        REQ_B_A1     = 5'd15,
        REQ_BLX_A2   = 5'd16
    } req_kind_t;

    localparam logic [1:0] SET_ARM = 2'd0;
    localparam logic [1:0] SET_T16 = 2'd1;

    localparam logic [31:0] ALIGN4_MASK = 32'hffff_fffc;

    // 16-bit patterns, checked on the low halfword
    localparam logic [15:0] CBZ_MASK  = 16'hf500;
    localparam logic [15:0] CBZ_VAL   = 16'hb100;
    localparam logic [15:0] ADR1_MASK = 16'hf800;
    localparam logic [15:0] ADR1_VAL  = 16'ha000;
    localparam logic [15:0] LDR1_MASK = 16'hf800;
    localparam logic [15:0] LDR1_VAL  = 16'h4800;
    localparam logic [15:0] BT1_MASK  = 16'hf000;
    localparam logic [15:0] BT1_VAL   = 16'hd000;
    localparam logic [15:0] SVC_MASK  = 16'hfe00;
    localparam logic [15:0] SVC_VAL   = 16'hde00;
    localparam logic [15:0] BT2_MASK  = 16'hf800;
    localparam logic [15:0] BT2_VAL   = 16'he000;

    // 32-bit patterns
    localparam logic [31:0] ADR23_MASK = 32'hfbff_8000;
    localparam logic [31:0] ADR2_VAL   = 32'hf2af_0000;
    localparam logic [31:0] ADR3_VAL   = 32'hf20f_0000;
    localparam logic [31:0] LDR2_MASK  = 32'hff7f_0000;
    localparam logic [31:0] LDR2_VAL   = 32'hf85f_0000;
    localparam logic [31:0] BT3_MASK   = 32'hf800_d000;
    localparam logic [31:0] BT3_VAL    = 32'hf000_8000;
    localparam logic [31:0] BLX2_MASK  = 32'hf800_c000;
    localparam logic [31:0] BLX2_VAL   = 32'hf000_c000;

    // decoded word after the first stage
    typedef struct packed {
        logic [31:0] src;
        logic [3:0]  inc;
        logic [31:0] off;
        logic        sub;
        logic        align;
        logic        thumb;
        logic        half;
        logic        bad;
    } dec_t;

    // word after the base add
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] off;
        logic        sub;
        logic        align;
        logic        thumb;
        logic        half;
        logic        bad;
    } base_t;

endpackage

// ----- design/arm_thumb_pc_relative_value_unit.sv -----
// ----------------------------------------------------------------------------
// arm_thumb_pc_relative_value_unit: pc-relative value and branch target unit
// three-stage pipeline: decode, base add, align / offset add / thumb bit
// ----------------------------------------------------------------------------
// One request word in, one result word out, one word per cycle sustained while
// the output is not stalled. Every request kind goes through the same path:
// value = (align(src + inc) +/- offset) | thumb. Stage one decodes the kind,
// checks the encoding and builds the sign-extended offset; stage two adds the
// pc increment (0, 2, 4 or 8) to the source; stage three clears the low bits
// where the base is word aligned, adds or subtracts the offset and sets the
// thumb bit, into the output register. Each stage moves on when the stage
// after it is empty or moving, so a stall on the output backs up the pipe
// without dropping or repeating a word, and bubbles are squeezed out. The
// unit keeps no state between words and has no configuration.
module arm_thumb_pc_relative_value_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  req_type,
    input  logic [31:0] pc,
    input  logic [31:0] insn,
    input  logic [1:0]  insn_set,
    input  logic [31:0] handler_addr,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    output logic        value_is_halfword,
    output logic        bad_encoding
);

    // pipeline valid bits and stage registers
    logic                s1_valid_reg, s1_valid_next;
    logic                s2_valid_reg, s2_valid_next;
    logic                s3_valid_reg, s3_valid_next;
    atpcv_pkg::dec_t     s1_reg, s1_next;
    atpcv_pkg::base_t    s2_reg, s2_next;
    logic [31:0]         val_reg, val_next;
    logic                half_reg, half_next;
    logic                bad_reg, bad_next;

    // stage enables, from the output back to the input
    logic en1, en2, en3;

    assign en3 = !s3_valid_reg || out_ready;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_ready = en1;

    // ------------------------------------------------------------------
    // stage 1: decode
    // ------------------------------------------------------------------
    logic        is_arm, is_t16;
    logic [15:0] lo16;
    logic        s_bit, i1, i2;
    logic [31:0] long_off;
    logic        adr_t2, adr_t3;

    assign is_arm = (insn_set == atpcv_pkg::SET_ARM);
    assign is_t16 = (insn_set == atpcv_pkg::SET_T16);
    assign lo16   = insn[15:0];

    // S:I1:I2:imm10:imm11:0, I = not (J xor S)
    assign s_bit    = insn[26];
    assign i1       = ~(s_bit ^ insn[13]);
    assign i2       = ~(s_bit ^ insn[11]);
    assign long_off = {{7{s_bit}}, s_bit, i1, i2, insn[25:16], insn[10:0], 1'b0};

    assign adr_t2 = ((insn & atpcv_pkg::ADR23_MASK) == atpcv_pkg::ADR2_VAL);
    assign adr_t3 = ((insn & atpcv_pkg::ADR23_MASK) == atpcv_pkg::ADR3_VAL);

    always_comb
    begin
        s1_next       = '0;
        s1_next.src   = pc;
        unique case (atpcv_pkg::req_kind_t'(req_type))
            atpcv_pkg::REQ_HANDLER:
            begin
                s1_next.src = handler_addr;
            end
            atpcv_pkg::REQ_ORIG_PC:
            begin
                s1_next.thumb = !is_arm;
            end
            atpcv_pkg::REQ_READ_PC:
            begin
                s1_next.inc = is_arm ? 4'd8 : 4'd4;
            end
            atpcv_pkg::REQ_NEXT_PC:
            begin
                s1_next.inc   = is_t16 ? 4'd2 : 4'd4;
                s1_next.thumb = !is_arm;
            end
            atpcv_pkg::REQ_INSN:
            begin
                if (is_t16)
                begin
                    s1_next.src  = {16'h0000, lo16};
                    s1_next.half = 1'b1;
                    s1_next.bad  = (insn[31:16] != 16'h0000);
                end
                else if (is_arm)
                begin
                    s1_next.src = insn;
                end
                else
                begin
                    // thumb-2: first halfword goes low
                    s1_next.src = {insn[15:0], insn[31:16]};
                end
            end
            atpcv_pkg::REQ_CBZ:
            begin
                s1_next.inc   = 4'd4;
                s1_next.off   = {25'h0, insn[9], insn[7:3], 1'b0};
                s1_next.thumb = 1'b1;
                s1_next.bad   = ((lo16 & atpcv_pkg::CBZ_MASK) != atpcv_pkg::CBZ_VAL);
            end
            atpcv_pkg::REQ_ADR_T1:
            begin
                s1_next.inc   = 4'd4;
                s1_next.align = 1'b1;
                s1_next.off   = {22'h0, insn[7:0], 2'b00};
                s1_next.bad   = ((lo16 & atpcv_pkg::ADR1_MASK) != atpcv_pkg::ADR1_VAL);
            end
            atpcv_pkg::REQ_ADR_T23:
            begin
                s1_next.inc   = 4'd4;
                s1_next.align = 1'b1;
                s1_next.off   = {20'h0, insn[26], insn[14:12], insn[7:0]};
                s1_next.sub   = adr_t2;
                s1_next.bad   = !(adr_t2 || adr_t3);
            end
            atpcv_pkg::REQ_LDR_T1:
            begin
                s1_next.inc   = 4'd4;
                s1_next.align = 1'b1;
                s1_next.off   = {22'h0, insn[7:0], 2'b00};
                s1_next.bad   = ((lo16 & atpcv_pkg::LDR1_MASK) != atpcv_pkg::LDR1_VAL);
            end
            atpcv_pkg::REQ_LDR_T2:
            begin
                s1_next.inc   = 4'd4;
                s1_next.align = 1'b1;
                s1_next.off   = {20'h0, insn[11:0]};
                s1_next.sub   = !insn[23];
                s1_next.bad   = ((insn & atpcv_pkg::LDR2_MASK) != atpcv_pkg::LDR2_VAL);
            end
            atpcv_pkg::REQ_B_T1:
            begin
                s1_next.inc   = 4'd4;
                s1_next.off   = {{23{insn[7]}}, insn[7:0], 1'b0};
                s1_next.thumb = 1'b1;
                // svc / undefined space also counts as a mismatch
                s1_next.bad   = ((lo16 & atpcv_pkg::BT1_MASK) != atpcv_pkg::BT1_VAL)
                             || ((lo16 & atpcv_pkg::SVC_MASK) == atpcv_pkg::SVC_VAL);
            end
            atpcv_pkg::REQ_B_T2:
            begin
                s1_next.inc   = 4'd4;
                s1_next.off   = {{20{insn[10]}}, insn[10:0], 1'b0};
                s1_next.thumb = 1'b1;
                s1_next.bad   = ((lo16 & atpcv_pkg::BT2_MASK) != atpcv_pkg::BT2_VAL);
            end
            atpcv_pkg::REQ_B_T3:
            begin
                // S:J2:J1:imm6:imm11:0
                s1_next.inc   = 4'd4;
                s1_next.off   = {{11{insn[26]}}, insn[26], insn[11], insn[13],
                                 insn[21:16], insn[10:0], 1'b0};
                s1_next.thumb = 1'b1;
                s1_next.bad   = ((insn & atpcv_pkg::BT3_MASK) != atpcv_pkg::BT3_VAL);
            end
            atpcv_pkg::REQ_B_T4:
            begin
                s1_next.inc   = 4'd4;
                s1_next.off   = long_off;
                s1_next.thumb = 1'b1;
            end
            atpcv_pkg::REQ_BLX_T2:
            begin
                s1_next.inc   = 4'd4;
                s1_next.align = 1'b1;
                s1_next.off   = long_off;
                s1_next.bad   = ((insn & atpcv_pkg::BLX2_MASK) != atpcv_pkg::BLX2_VAL)
                             || insn[0];
            end
            atpcv_pkg::REQ_B_A1:
            begin
                s1_next.inc = 4'd8;
                s1_next.off = {{6{insn[23]}}, insn[23:0], 2'b00};
            end
            atpcv_pkg::REQ_BLX_A2:
            begin
                s1_next.inc   = 4'd8;
                s1_next.off   = {{6{insn[23]}}, insn[23:0], insn[24], 1'b0};
                s1_next.thumb = 1'b1;
            end
            default:
            begin
                // undefined kinds give zero and a flag
                s1_next.src = '0;
                s1_next.bad = 1'b1;
            end
        endcase
    end

    assign s1_valid_next = en1 ? in_valid : s1_valid_reg;

    // ------------------------------------------------------------------
    // stage 2: base add
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_next.base  = s1_reg.src + {28'h0, s1_reg.inc};
        s2_next.off   = s1_reg.off;
        s2_next.sub   = s1_reg.sub;
        s2_next.align = s1_reg.align;
        s2_next.thumb = s1_reg.thumb;
        s2_next.half  = s1_reg.half;
        s2_next.bad   = s1_reg.bad;
    end

    assign s2_valid_next = en2 ? s1_valid_reg : s2_valid_reg;

    // ------------------------------------------------------------------
    // stage 3: align, offset add, thumb bit
    // ------------------------------------------------------------------
    logic [31:0] abase, sum;

    assign abase = s2_reg.align ? (s2_reg.base & atpcv_pkg::ALIGN4_MASK) : s2_reg.base;
    assign sum   = s2_reg.sub ? (abase - s2_reg.off) : (abase + s2_reg.off);

    assign val_next      = sum | {31'h0, s2_reg.thumb};
    assign half_next     = s2_reg.half;
    assign bad_next      = s2_reg.bad;
    assign s3_valid_next = en3 ? s2_valid_reg : s3_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // payload, loaded only when the stage moves
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            val_reg  <= val_next;
            half_reg <= half_next;
            bad_reg  <= bad_next;
        end
    end

    assign out_valid         = s3_valid_reg;
    assign value             = val_reg;
    assign value_is_halfword = half_reg;
    assign bad_encoding      = bad_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a halfword result never carries upper bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && value_is_halfword) |-> (value[31:16] == 16'h0000))
    else $error("halfword result with upper bits set");

    // input only stalls when the whole pipe is full and the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && !out_ready))
    else $error("input stalled with room in the pipe");

    // a stalled decode word holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en2) |=> (s1_valid_reg && $stable(s1_reg)))
    else $error("decode stage lost or changed a stalled word");

    // a stalled base word holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !en3) |=> (s2_valid_reg && $stable(s2_reg)))
    else $error("base stage lost or changed a stalled word");

endmodule

// ----- dv/tb_arm_thumb_pc_relative_value_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arm_thumb_pc_relative_value_unit: self-checking bench for the pc value unit
// directed encodings per request kind, then shaped random traffic under four
// pacing phases; every result is checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_arm_thumb_pc_relative_value_unit;

    // thumb-2 set codes, the fourth code decodes like thumb-2
    localparam logic [1:0] SET_T32     = 2'd2;
    localparam logic [1:0] SET_T32_ALT = 2'd3;

    // request kinds past the last defined one
    localparam logic [4:0] REQ_UNDEF_LO = 5'd17;
    localparam logic [4:0] REQ_UNDEF_HI = 5'd31;

    // b.w / bl shape, only used to steer random stimulus
    localparam logic [31:0] BT4_MASK = 32'hf800_d000;
    localparam logic [31:0] BT4_VAL  = 32'hf000_9000;

    localparam int RANDOM_WORDS_PER_PHASE = 120;
    localparam int PIPE_LATENCY           = 3;
    localparam int STALL_LIMIT            = 4000;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] pc;
        logic [31:0] val;
        logic        half;
        logic        bad;
    } pcv_result_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [4:0]  req_type     = '0;
    logic [31:0] pc           = '0;
    logic [31:0] insn         = '0;
    logic [1:0]  insn_set     = '0;
    logic [31:0] handler_addr = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [31:0] value;
    logic        value_is_halfword;
    logic        bad_encoding;

    // pacing, in percent of cycles
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;

    pcv_result_t pending_results[$];
    int unsigned n_words_sent      = 0;
    int unsigned n_results_checked = 0;
    int unsigned n_flagged         = 0;
    int unsigned n_halfword        = 0;
    int unsigned n_mismatches      = 0;
    int unsigned idle_cycles       = 0;

    arm_thumb_pc_relative_value_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .pc                (pc),
        .insn              (insn),
        .insn_set          (insn_set),
        .handler_addr      (handler_addr),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .value             (value),
        .value_is_halfword (value_is_halfword),
        .bad_encoding      (bad_encoding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // S:I1:I2:imm10:imm11:0 with I = NOT(J xor S), sign extended from 25 bits
    function automatic logic [31:0] long_branch_offset(input logic [31:0] w);
        logic s;
        logic i1;
        logic i2;
        s  = w[26];
        i1 = ~(s ^ w[13]);
        i2 = ~(s ^ w[11]);
        return {{7{s}}, s, i1, i2, w[25:16], w[10:0], 1'b0};
    endfunction

    function automatic pcv_result_t compute_pc_value(input logic [4:0]  kind,
                                                     input logic [31:0] p,
                                                     input logic [31:0] w,
                                                     input logic [1:0]  set,
                                                     input logic [31:0] handler);
        pcv_result_t r;
        logic        is_arm;
        logic        is_t16;
        logic        t2_form;
        logic        t3_form;
        logic [31:0] word_base;
        logic [31:0] imm;
        logic [31:0] off;
        is_arm    = (set == atpcv_pkg::SET_ARM);
        is_t16    = (set == atpcv_pkg::SET_T16);
        // thumb literal base: read pc with the low two bits cleared
        word_base = (p + 32'd4) & atpcv_pkg::ALIGN4_MASK;
        r         = '0;
        r.kind    = kind;
        r.pc      = p;
        case (kind)
            atpcv_pkg::REQ_HANDLER: r.val = handler;
            atpcv_pkg::REQ_ORIG_PC: r.val = p | {31'd0, ~is_arm};
            atpcv_pkg::REQ_READ_PC: r.val = p + (is_arm ? 32'd8 : 32'd4);
            atpcv_pkg::REQ_NEXT_PC:
                r.val = (p + (is_t16 ? 32'd2 : 32'd4)) | {31'd0, ~is_arm};
            atpcv_pkg::REQ_INSN:
            begin
                if (is_t16)
                begin
                    r.val  = {16'd0, w[15:0]};
                    r.half = 1'b1;
                    r.bad  = |w[31:16];
                end
                else if (is_arm)
                    r.val = w;
                else
                    r.val = {w[15:0], w[31:16]};
            end
            atpcv_pkg::REQ_CBZ:
            begin
                imm   = {25'd0, w[9], w[7:3], 1'b0};
                r.bad = (w[15:0] & atpcv_pkg::CBZ_MASK) != atpcv_pkg::CBZ_VAL;
                r.val = (p + 32'd4 + imm) | 32'd1;
            end
            atpcv_pkg::REQ_ADR_T1:
            begin
                r.bad = (w[15:0] & atpcv_pkg::ADR1_MASK) != atpcv_pkg::ADR1_VAL;
                r.val = word_base + {22'd0, w[7:0], 2'b00};
            end
            atpcv_pkg::REQ_ADR_T23:
            begin
                t2_form = (w & atpcv_pkg::ADR23_MASK) == atpcv_pkg::ADR2_VAL;
                t3_form = (w & atpcv_pkg::ADR23_MASK) == atpcv_pkg::ADR3_VAL;
                imm     = {20'd0, w[26], w[14:12], w[7:0]};
                r.bad   = !(t2_form || t3_form);
                // only the subtracting form subtracts, anything else adds
                r.val   = t2_form ? (word_base - imm) : (word_base + imm);
            end
            atpcv_pkg::REQ_LDR_T1:
            begin
                r.bad = (w[15:0] & atpcv_pkg::LDR1_MASK) != atpcv_pkg::LDR1_VAL;
                r.val = word_base + {22'd0, w[7:0], 2'b00};
            end
            atpcv_pkg::REQ_LDR_T2:
            begin
                imm   = {20'd0, w[11:0]};
                r.bad = (w & atpcv_pkg::LDR2_MASK) != atpcv_pkg::LDR2_VAL;
                r.val = w[23] ? (word_base + imm) : (word_base - imm);
            end
            atpcv_pkg::REQ_B_T1:
            begin
                off   = {{23{w[7]}}, w[7:0], 1'b0};
                r.bad = ((w[15:0] & atpcv_pkg::BT1_MASK) != atpcv_pkg::BT1_VAL) ||
                        ((w[15:0] & atpcv_pkg::SVC_MASK) == atpcv_pkg::SVC_VAL);
                r.val = (p + 32'd4 + off) | 32'd1;
            end
            atpcv_pkg::REQ_B_T2:
            begin
                off   = {{20{w[10]}}, w[10:0], 1'b0};
                r.bad = (w[15:0] & atpcv_pkg::BT2_MASK) != atpcv_pkg::BT2_VAL;
                r.val = (p + 32'd4 + off) | 32'd1;
            end
            atpcv_pkg::REQ_B_T3:
            begin
                // S:J2:J1:imm6:imm11:0
                off   = {{11{w[26]}}, w[26], w[11], w[13], w[21:16], w[10:0], 1'b0};
                r.bad = (w & atpcv_pkg::BT3_MASK) != atpcv_pkg::BT3_VAL;
                r.val = (p + 32'd4 + off) | 32'd1;
            end
            atpcv_pkg::REQ_B_T4: r.val = (p + 32'd4 + long_branch_offset(w)) | 32'd1;
            atpcv_pkg::REQ_BLX_T2:
            begin
                r.bad = ((w & atpcv_pkg::BLX2_MASK) != atpcv_pkg::BLX2_VAL) || w[0];
                r.val = word_base + long_branch_offset(w);
            end
            atpcv_pkg::REQ_B_A1:
            begin
                off   = {{6{w[23]}}, w[23:0], 2'b00};
                r.val = p + 32'd8 + off;
            end
            atpcv_pkg::REQ_BLX_A2:
            begin
                // H bit lands on bit 1 of the offset
                off   = {{6{w[23]}}, w[23:0], w[24], 1'b0};
                r.val = (p + 32'd8 + off) | 32'd1;
            end
            default:
            begin
                r.val = '0;
                r.bad = 1'b1;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // offers one request word and returns at the edge that takes it
    task automatic send_word(input logic [4:0]  kind,
                             input logic [31:0] p,
                             input logic [31:0] w,
                             input logic [1:0]  set,
                             input logic [31:0] handler);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        pc           <= p;
        insn         <= w;
        insn_set     <= set;
        handler_addr <= handler;
        do
            @(posedge clk);
        while (!in_ready);
        n_words_sent++;
    endtask

    // stops sending and holds off until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver pacing
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // ------------------------------------------------------------------------
    // result checking: capture accepted requests, compare accepted results
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        pcv_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_results.push_back(
                    compute_pc_value(req_type, pc, insn, insn_set, handler_addr));
            if (out_valid && out_ready)
            begin
                n_results_checked++;
                if (bad_encoding === 1'b1)
                    n_flagged++;
                if (value_is_halfword === 1'b1)
                    n_halfword++;
                if (pending_results.size() == 0)
                begin
                    n_mismatches++;
                    if (n_mismatches <= 10)
                        $display("[%0t] unexpected result word: value %h half %b bad %b",
                                 $realtime, value, value_is_halfword, bad_encoding);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (value !== want.val || value_is_halfword !== want.half ||
                        bad_encoding !== want.bad)
                    begin
                        n_mismatches++;
                        if (n_mismatches <= 10)
                            $display("[%0t] mismatch kind %0d pc %h: exp %h/%b/%b got %h/%b/%b",
                                     $realtime, want.kind, want.pc, want.val, want.half,
                                     want.bad, value, value_is_halfword, bad_encoding);
                    end
                end
            end
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // handler, pc forms at the top of the address space, instruction words
    task automatic test_pc_and_word_kinds();
        send_word(atpcv_pkg::REQ_HANDLER, 32'h0000_0000, 32'h0000_0000,
                  atpcv_pkg::SET_ARM, 32'hffff_ffff);
        send_word(atpcv_pkg::REQ_ORIG_PC, 32'hffff_ffff, 32'hffff_ffff,
                  atpcv_pkg::SET_T16, 32'h0000_0000);
        send_word(atpcv_pkg::REQ_READ_PC, 32'hffff_fffc, 32'h0000_0000,
                  atpcv_pkg::SET_ARM, 32'h0000_0000);
        send_word(atpcv_pkg::REQ_NEXT_PC, 32'hffff_fffe, 32'h0000_0000,
                  atpcv_pkg::SET_T16, 32'h0000_0000);
        // clean halfword, then a halfword with junk in the upper half
        send_word(atpcv_pkg::REQ_INSN, 32'h0000_1000, 32'h0000_ffff,
                  atpcv_pkg::SET_T16, 32'h0000_0000);
        send_word(atpcv_pkg::REQ_INSN, 32'h0000_1000, 32'h0001_4800,
                  atpcv_pkg::SET_T16, 32'h0000_0000);
        // fourth set code swaps halfwords like thumb-2
        send_word(atpcv_pkg::REQ_INSN, 32'h0000_1000, 32'hf000_f800,
                  SET_T32_ALT, 32'h0000_0000);
        wait_drained();
    endtask

    // cbz, adr and literal loads, good and broken encodings
    task automatic test_literal_and_adr();
        send_word(atpcv_pkg::REQ_CBZ,     32'hffff_fff0, 32'h0000_bbf8,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_CBZ,     32'h0000_0100, 32'h0000_b200,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_ADR_T1,  32'h0000_0002, 32'h0000_a0ff,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_ADR_T23, 32'h0000_0002, 32'hf6af_70ff, SET_T32, 32'h0);
        send_word(atpcv_pkg::REQ_ADR_T23, 32'hffff_fffe, 32'hf60f_7fff, SET_T32, 32'h0);
        // neither adr form: offset still added, flag raised
        send_word(atpcv_pkg::REQ_ADR_T23, 32'h0000_4000, 32'hffff_ffff, SET_T32, 32'h0);
        send_word(atpcv_pkg::REQ_LDR_T1,  32'hffff_fffe, 32'h0000_48ff,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_LDR_T2,  32'h0000_0000, 32'hf85f_0fff, SET_T32, 32'h0);
        wait_drained();
    endtask

    // every branch form, all but b.w / bl with sign bits set, svc space and odd blx
    task automatic test_branches();
        send_word(atpcv_pkg::REQ_B_T1,   32'h0000_0000, 32'h0000_d080,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_B_T1,   32'h0000_0200, 32'h0000_de12,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_B_T2,   32'h0000_0000, 32'h0000_e400,
                  atpcv_pkg::SET_T16, 32'h0);
        send_word(atpcv_pkg::REQ_B_T3,   32'h0010_0000, 32'hf400_8000, SET_T32, 32'h0);
        send_word(atpcv_pkg::REQ_B_T4,   32'hff00_0000, 32'hf000_9000, SET_T32, 32'h0);
        send_word(atpcv_pkg::REQ_BLX_T2, 32'h0000_0002, 32'hf7ff_efff, SET_T32, 32'h0);
        send_word(atpcv_pkg::REQ_B_A1,   32'h0000_0000, 32'h0a80_0000,
                  atpcv_pkg::SET_ARM, 32'h0);
        send_word(atpcv_pkg::REQ_BLX_A2, 32'hffff_fff8, 32'hfb80_0000,
                  atpcv_pkg::SET_ARM, 32'h0);
        wait_drained();
    endtask

    // kinds past the defined range give zero with the flag
    task automatic test_undefined_kinds();
        send_word(REQ_UNDEF_LO, 32'h1234_5678, 32'hffff_ffff, SET_T32, 32'hffff_ffff);
        send_word(REQ_UNDEF_HI, 32'hffff_ffff, 32'hffff_ffff, atpcv_pkg::SET_ARM,
                  32'hffff_ffff);
        wait_drained();
    endtask

    // instruction set that fits the kind most of the time
    function automatic logic [1:0] pick_set(input logic [4:0] kind);
        if ($urandom_range(0, 4) == 0)
            return 2'($urandom_range(0, 3));
        case (kind)
            atpcv_pkg::REQ_CBZ, atpcv_pkg::REQ_ADR_T1, atpcv_pkg::REQ_LDR_T1,
            atpcv_pkg::REQ_B_T1, atpcv_pkg::REQ_B_T2:
                return atpcv_pkg::SET_T16;
            atpcv_pkg::REQ_ADR_T23, atpcv_pkg::REQ_LDR_T2, atpcv_pkg::REQ_B_T3,
            atpcv_pkg::REQ_B_T4, atpcv_pkg::REQ_BLX_T2:
                return $urandom_range(0, 3) == 0 ? SET_T32_ALT : SET_T32;
            atpcv_pkg::REQ_B_A1, atpcv_pkg::REQ_BLX_A2:
                return atpcv_pkg::SET_ARM;
            default:
                return 2'($urandom_range(0, 3));
        endcase
    endfunction

    // random instruction, mostly forced onto the kind's encoding
    function automatic logic [31:0] shaped_insn(input logic [4:0] kind,
                                                input logic [1:0] set);
        logic [31:0] w;
        logic [31:0] m;
        logic [31:0] v;
        w = $urandom;
        m = '0;
        v = '0;
        case (kind)
            atpcv_pkg::REQ_INSN:
                if (set == atpcv_pkg::SET_T16 && $urandom_range(0, 3) != 0)
                    w[31:16] = '0;
            atpcv_pkg::REQ_CBZ:
            begin
                m = {16'd0, atpcv_pkg::CBZ_MASK};
                v = {16'd0, atpcv_pkg::CBZ_VAL};
            end
            atpcv_pkg::REQ_ADR_T1:
            begin
                m = {16'd0, atpcv_pkg::ADR1_MASK};
                v = {16'd0, atpcv_pkg::ADR1_VAL};
            end
            atpcv_pkg::REQ_ADR_T23:
            begin
                m = atpcv_pkg::ADR23_MASK;
                v = $urandom_range(0, 1) ? atpcv_pkg::ADR2_VAL : atpcv_pkg::ADR3_VAL;
            end
            atpcv_pkg::REQ_LDR_T1:
            begin
                m = {16'd0, atpcv_pkg::LDR1_MASK};
                v = {16'd0, atpcv_pkg::LDR1_VAL};
            end
            atpcv_pkg::REQ_LDR_T2:
            begin
                m = atpcv_pkg::LDR2_MASK;
                v = atpcv_pkg::LDR2_VAL;
            end
            atpcv_pkg::REQ_B_T1:
            begin
                // now and then land in the svc / undefined space
                if ($urandom_range(0, 4) == 0)
                begin
                    m = {16'd0, atpcv_pkg::SVC_MASK};
                    v = {16'd0, atpcv_pkg::SVC_VAL};
                end
                else
                begin
                    m = {16'd0, atpcv_pkg::BT1_MASK};
                    v = {16'd0, atpcv_pkg::BT1_VAL};
                end
            end
            atpcv_pkg::REQ_B_T2:
            begin
                m = {16'd0, atpcv_pkg::BT2_MASK};
                v = {16'd0, atpcv_pkg::BT2_VAL};
            end
            atpcv_pkg::REQ_B_T3:
            begin
                m = atpcv_pkg::BT3_MASK;
                v = atpcv_pkg::BT3_VAL;
            end
            atpcv_pkg::REQ_B_T4:
            begin
                m = BT4_MASK;
                v = BT4_VAL;
            end
            atpcv_pkg::REQ_BLX_T2:
            begin
                m = atpcv_pkg::BLX2_MASK;
                v = atpcv_pkg::BLX2_VAL;
            end
            default: ;
        endcase
        if (m != '0 && $urandom_range(0, 3) != 0)
            w = (w & ~m) | v;
        if (kind == atpcv_pkg::REQ_BLX_T2 && $urandom_range(0, 3) != 0)
            w[0] = 1'b0;
        return w;
    endfunction

    // shaped random words under no idling, sender gaps, receiver stalls, both
    task automatic test_random_traffic();
        logic [4:0]  kind;
        logic [1:0]  set;
        logic [31:0] p;
        int unsigned src_pct[4]  = '{0, 55, 0, 23};
        int unsigned sink_pct[4] = '{0, 0, 55, 23};
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            for (int i = 0; i < RANDOM_WORDS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    kind = 5'($urandom_range(REQ_UNDEF_LO, REQ_UNDEF_HI));
                else
                    kind = 5'($urandom_range(atpcv_pkg::REQ_HANDLER,
                                             atpcv_pkg::REQ_BLX_A2));
                set = pick_set(kind);
                case ($urandom_range(0, 7))
                    0:       p = 32'hffff_fff0 | 32'($urandom_range(0, 15));
                    1:       p = 32'($urandom_range(0, 15));
                    default: p = $urandom;
                endcase
                send_word(kind, p, shaped_insn(kind, set), set, $urandom);
            end
            // sender holds off until the pipe is empty before the next phase
            wait_drained();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pc_and_word_kinds();
        test_literal_and_adr();
        test_branches();
        test_undefined_kinds();
        test_random_traffic();

        wait_drained();
        repeat (4 * PIPE_LATENCY) @(posedge clk);
        n_mismatches += pending_results.size();

        $display("covered %0d request words over all kinds, both thumb-2 set codes and",
                 n_words_sent);
        $display("four pacing phases; %0d results checked, %0d flagged, %0d halfwords",
                 n_results_checked, n_flagged, n_halfword);
        if (n_mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
